>>> rtl/core/tds_pkg.sv
// Shared constants, operation codes and status struct for the tridiagonal solver.
package tds_pkg;

   localparam int DEF_MAX_SIZE   = 64;
   localparam int DEF_VALUE_BITS = 32;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_BITS       = 7;
   localparam int COEF_BITS      = 32;
   localparam int INDEX_BITS     = 6;
   localparam int OP_BITS        = 5;

   localparam logic [1:0] ST_SETUP_OK  = 2'd0;
   localparam logic [1:0] ST_SINGULAR  = 2'd1;
   localparam logic [1:0] ST_NOT_READY = 2'd2;
   localparam logic [1:0] ST_SOLUTION  = 2'd3;

   localparam logic CMD_ROW = 1'b0;
   localparam logic CMD_RHS = 1'b1;

   localparam logic [OP_BITS-1:0] OP_NONE      = 5'd0;
   localparam logic [OP_BITS-1:0] OP_LATCH     = 5'd1;
   localparam logic [OP_BITS-1:0] OP_ROW0      = 5'd2;
   localparam logic [OP_BITS-1:0] OP_DIV_L     = 5'd3;
   localparam logic [OP_BITS-1:0] OP_MUL_SL    = 5'd4;
   localparam logic [OP_BITS-1:0] OP_ROW_WR    = 5'd5;
   localparam logic [OP_BITS-1:0] OP_ROW_ADV   = 5'd6;
   localparam logic [OP_BITS-1:0] OP_NOT_READY = 5'd7;
   localparam logic [OP_BITS-1:0] OP_FWD0      = 5'd8;
   localparam logic [OP_BITS-1:0] OP_MUL_FL    = 5'd9;
   localparam logic [OP_BITS-1:0] OP_FWD_WR    = 5'd10;
   localparam logic [OP_BITS-1:0] OP_RHS_ADV   = 5'd11;
   localparam logic [OP_BITS-1:0] OP_NUM_FWD   = 5'd12;
   localparam logic [OP_BITS-1:0] OP_MUL_SN    = 5'd13;
   localparam logic [OP_BITS-1:0] OP_SUB_N     = 5'd14;
   localparam logic [OP_BITS-1:0] OP_DIV_N     = 5'd15;
   localparam logic [OP_BITS-1:0] OP_SOL_OUT   = 5'd16;
   localparam logic [OP_BITS-1:0] OP_BACK_DEC  = 5'd17;

   typedef struct packed {
      logic unit_done;
      logic is_rhs;
      logic row_first;
      logic row_last;
      logic rhs_first;
      logic rhs_last;
      logic back_top;
      logic back_zero;
      logic ready;
   } tds_stat_type;

endpackage

>>> rtl/core/tds_arith.sv
// Serial fixed-point multiply and divide unit with saturation.
module tds_arith
   import tds_pkg::*;
#(
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         is_div,
   input  logic signed [VALUE_BITS-1:0] op_a,
   input  logic signed [VALUE_BITS-1:0] op_b,
   output logic                         done,
   output logic signed [VALUE_BITS-1:0] result
);

   localparam int W  = VALUE_BITS;
   localparam int PW = 2 * W;
   localparam int QW = W + FRAC_BITS;
   localparam int CW = $clog2(QW + 1);

   logic          busy_ff, fin_ff, done_ff;
   logic [CW-1:0] cnt_ff;
   logic          div_ff, neg_ff, bz_ff;
   logic [W-1:0]  ma_ff;
   logic [PW:0]   acc_ff;
   logic [W-1:0]  rem_ff;
   logic [QW-1:0] quo_ff;
   logic signed [W-1:0] res_ff;

   logic [W:0]    mul_sum;
   logic [W:0]    div_t;
   logic          div_ge;
   logic [CW-1:0] last_cnt;
   logic [PW-1:0] mag_full;
   logic signed [W-1:0] sat_val;

   function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] v);
      return v[W-1] ? W'(-v) : W'(v);
   endfunction

   assign mul_sum  = acc_ff[PW:W] + {1'b0, ma_ff};
   assign div_t    = {rem_ff, quo_ff[QW-1]};
   assign div_ge   = div_t >= {1'b0, ma_ff};
   assign last_cnt = div_ff ? CW'(QW - 1) : CW'(W - 1);

   always_comb begin
      logic [PW-1:0] half;
      half = PW'(1) << (W - 1);
      if (div_ff) begin
         mag_full = PW'(quo_ff);
      end else begin
         mag_full = PW'(acc_ff[PW-1:FRAC_BITS]);
      end
      if (div_ff && bz_ff) begin
         sat_val = '0;
      end else if (!neg_ff) begin
         sat_val = (mag_full > half - PW'(1)) ? W'(half - PW'(1)) : W'(mag_full);
      end else begin
         sat_val = (mag_full >= half) ? W'(half) : W'(-mag_full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == last_cnt) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         div_ff <= is_div;
         neg_ff <= op_a[W-1] ^ op_b[W-1];
         bz_ff  <= (op_b == '0);
         if (is_div) begin
            ma_ff  <= mag_of(op_b);
            rem_ff <= '0;
            quo_ff <= {mag_of(op_a), FRAC_BITS'(0)};
         end else begin
            ma_ff  <= mag_of(op_a);
            acc_ff <= {(W + 1)'(0), mag_of(op_b)};
         end
      end else if (busy_ff) begin
         if (div_ff) begin
            rem_ff <= div_ge ? W'(div_t - {1'b0, ma_ff}) : W'(div_t);
            quo_ff <= {quo_ff[QW-2:0], div_ge};
         end else begin
            acc_ff <= {1'b0, (acc_ff[0] ? mul_sum : acc_ff[PW:W]), acc_ff[W-1:1]};
         end
      end
      if (fin_ff) begin
         res_ff <= sat_val;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> rtl/core/tds_datapath.sv
// Factor and forward-substitution stores, working registers and response payload.
module tds_datapath
   import tds_pkg::*;
#(
   parameter int MAX_SIZE   = DEF_MAX_SIZE,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_BITS-1:0]         csr_wdata,
   input  logic                        req_cmd,
   input  logic signed [COEF_BITS-1:0] req_sub_coef,
   input  logic signed [COEF_BITS-1:0] req_main_coef,
   input  logic signed [COEF_BITS-1:0] req_super_coef,
   input  logic signed [COEF_BITS-1:0] req_rhs_value,
   input  logic [OP_BITS-1:0]          op,
   output tds_stat_type                stat,
   output logic [1:0]                  rsp_status,
   output logic [INDEX_BITS-1:0]       rsp_index,
   output logic signed [COEF_BITS-1:0] rsp_value,
   output logic                        rsp_last
);

   localparam int W  = VALUE_BITS;
   localparam int IW = $clog2(MAX_SIZE);

   logic signed [W-1:0] upper_mem [MAX_SIZE];
   logic signed [W-1:0] super_mem [MAX_SIZE];
   logic signed [W-1:0] lower_mem [MAX_SIZE];
   logic signed [W-1:0] fwd_mem   [MAX_SIZE];

   logic signed [W-1:0] lower_rd_ff, fwd_rd_ff, super_rd_ff, upper_rd_ff;
   logic                cmd_ff;
   logic signed [W-1:0] sub_ff, main_ff, super_ff, rhs_ff;
   logic signed [W-1:0] prev_upper_ff, prev_super_ff, prev_fwd_ff;
   logic signed [W-1:0] lmul_ff, next_ff, num_ff;
   logic [IW-1:0]       last_idx_ff, row_cnt_ff, rhs_cnt_ff, back_r_ff;
   logic                ready_ff, sing_ff;
   logic [1:0]          status_ff;
   logic [INDEX_BITS-1:0] index_ff;
   logic signed [COEF_BITS-1:0] value_ff;
   logic                last_ff;

   logic                u_start, u_div, u_done;
   logic signed [W-1:0] u_a, u_b, u_res;
   logic signed [W-1:0] sub_op_a, sub_op_b, sub_res;
   logic [7:0]          eff_size;

   function automatic logic signed [W-1:0] fx_in(input logic signed [COEF_BITS-1:0] x);
      logic signed [63:0] x64, maxv, minv;
      x64  = 64'(x);
      maxv = (64'sd1 <<< (W - 1)) - 64'sd1;
      minv = -maxv - 64'sd1;
      if (x64 > maxv) begin
         x64 = maxv;
      end else if (x64 < minv) begin
         x64 = minv;
      end
      return W'(x64);
   endfunction

   function automatic logic signed [COEF_BITS-1:0] fx_out(input logic signed [W-1:0] v);
      logic signed [63:0] v64;
      v64 = 64'(v);
      if (v64 > 64'sd2147483647) begin
         v64 = 64'sd2147483647;
      end else if (v64 < -64'sd2147483648) begin
         v64 = -64'sd2147483648;
      end
      return COEF_BITS'(v64);
   endfunction

   function automatic logic signed [W-1:0] fx_sub(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
      logic [W:0] d;
      d = {a[W-1], a} - {b[W-1], b};
      if (d[W] != d[W-1]) begin
         return d[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
      end
      return W'(d);
   endfunction

   tds_arith #(.VALUE_BITS(VALUE_BITS)) u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (u_start),
      .is_div (u_div),
      .op_a   (u_a),
      .op_b   (u_b),
      .done   (u_done),
      .result (u_res)
   );

   always_comb begin
      u_start = 1'b0;
      u_div   = 1'b0;
      u_a     = '0;
      u_b     = '0;
      case (op)
         OP_DIV_L: begin
            u_start = 1'b1; u_div = 1'b1; u_a = sub_ff; u_b = prev_upper_ff;
         end
         OP_MUL_SL: begin
            u_start = 1'b1; u_a = prev_super_ff; u_b = u_res;
         end
         OP_MUL_FL: begin
            u_start = 1'b1; u_a = prev_fwd_ff; u_b = lower_rd_ff;
         end
         OP_MUL_SN: begin
            u_start = 1'b1; u_a = super_rd_ff; u_b = next_ff;
         end
         OP_DIV_N: begin
            u_start = 1'b1; u_div = 1'b1; u_a = num_ff; u_b = upper_rd_ff;
         end
         default: begin
            u_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (op)
         OP_FWD_WR: sub_op_a = rhs_ff;
         OP_SUB_N:  sub_op_a = fwd_rd_ff;
         default:   sub_op_a = main_ff;
      endcase
      sub_op_b = u_res;
      sub_res  = fx_sub(sub_op_a, sub_op_b);
   end

   always_comb begin
      eff_size = 8'(csr_wdata);
      if (eff_size == 8'd0) begin
         eff_size = 8'd1;
      end else if (eff_size > 8'(MAX_SIZE)) begin
         eff_size = 8'(MAX_SIZE);
      end
   end

   always_ff @(posedge clock) begin
      lower_rd_ff <= lower_mem[rhs_cnt_ff];
      fwd_rd_ff   <= fwd_mem[back_r_ff];
      super_rd_ff <= super_mem[back_r_ff];
      upper_rd_ff <= upper_mem[back_r_ff];
      case (op)
         OP_ROW0: begin
            upper_mem[0] <= main_ff;
            lower_mem[0] <= '0;
            super_mem[0] <= super_ff;
         end
         OP_ROW_WR: begin
            upper_mem[row_cnt_ff] <= sub_res;
            lower_mem[row_cnt_ff] <= lmul_ff;
            super_mem[row_cnt_ff] <= super_ff;
         end
         OP_FWD0: begin
            fwd_mem[0] <= rhs_ff;
         end
         OP_FWD_WR: begin
            fwd_mem[rhs_cnt_ff] <= sub_res;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      case (op)
         OP_LATCH: begin
            cmd_ff   <= req_cmd;
            sub_ff   <= fx_in(req_sub_coef);
            main_ff  <= fx_in(req_main_coef);
            super_ff <= fx_in(req_super_coef);
            rhs_ff   <= fx_in(req_rhs_value);
         end
         OP_ROW0: begin
            prev_upper_ff <= main_ff;
            prev_super_ff <= super_ff;
         end
         OP_MUL_SL: begin
            lmul_ff <= u_res;
         end
         OP_ROW_WR: begin
            prev_upper_ff <= sub_res;
            prev_super_ff <= super_ff;
         end
         OP_FWD0: begin
            prev_fwd_ff <= rhs_ff;
         end
         OP_FWD_WR: begin
            prev_fwd_ff <= sub_res;
         end
         OP_NUM_FWD: begin
            num_ff <= fwd_rd_ff;
         end
         OP_SUB_N: begin
            num_ff <= sub_res;
         end
         OP_SOL_OUT: begin
            next_ff   <= u_res;
            status_ff <= ST_SOLUTION;
            index_ff  <= INDEX_BITS'(back_r_ff);
            value_ff  <= fx_out(u_res);
            last_ff   <= (back_r_ff == '0);
         end
         OP_ROW_ADV: begin
            status_ff <= sing_ff ? ST_SINGULAR : ST_SETUP_OK;
            index_ff  <= '0;
            value_ff  <= '0;
            last_ff   <= 1'b1;
         end
         OP_NOT_READY: begin
            status_ff <= ST_NOT_READY;
            index_ff  <= '0;
            value_ff  <= '0;
            last_ff   <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_idx_ff <= IW'(MAX_SIZE - 1);
         row_cnt_ff  <= '0;
         rhs_cnt_ff  <= '0;
         back_r_ff   <= '0;
         ready_ff    <= 1'b0;
         sing_ff     <= 1'b0;
      end else if (csr_we) begin
         last_idx_ff <= IW'(eff_size - 8'd1);
         row_cnt_ff  <= '0;
         rhs_cnt_ff  <= '0;
         ready_ff    <= 1'b0;
         sing_ff     <= 1'b0;
      end else begin
         case (op)
            OP_ROW0: begin
               ready_ff   <= 1'b0;
               sing_ff    <= (main_ff == '0);
               rhs_cnt_ff <= '0;
            end
            OP_ROW_WR: begin
               if (sub_res == '0) begin
                  sing_ff <= 1'b1;
               end
            end
            OP_ROW_ADV: begin
               if (row_cnt_ff == last_idx_ff) begin
                  row_cnt_ff <= '0;
                  ready_ff   <= !sing_ff;
               end else begin
                  row_cnt_ff <= row_cnt_ff + IW'(1);
               end
            end
            OP_RHS_ADV: begin
               if (rhs_cnt_ff == last_idx_ff) begin
                  rhs_cnt_ff <= '0;
                  back_r_ff  <= last_idx_ff;
               end else begin
                  rhs_cnt_ff <= rhs_cnt_ff + IW'(1);
               end
            end
            OP_BACK_DEC: begin
               back_r_ff <= back_r_ff - IW'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      stat.unit_done = u_done;
      stat.is_rhs    = (cmd_ff == CMD_RHS);
      stat.row_first = (row_cnt_ff == '0);
      stat.row_last  = (row_cnt_ff == last_idx_ff);
      stat.rhs_first = (rhs_cnt_ff == '0);
      stat.rhs_last  = (rhs_cnt_ff == last_idx_ff);
      stat.back_top  = (back_r_ff == last_idx_ff);
      stat.back_zero = (back_r_ff == '0);
      stat.ready     = ready_ff;
   end

   assign rsp_status = status_ff;
   assign rsp_index  = index_ff;
   assign rsp_value  = value_ff;
   assign rsp_last   = last_ff;

endmodule

>>> rtl/core/tds_ctrl.sv
// Controller state machine sequencing factorization and substitution.
module tds_ctrl
   import tds_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  tds_stat_type       stat,
   output logic [OP_BITS-1:0] op
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_WDIV1  = 4'd2;
   localparam logic [3:0] S_WMUL1  = 4'd3;
   localparam logic [3:0] S_ROWEND = 4'd4;
   localparam logic [3:0] S_WMUL2  = 4'd5;
   localparam logic [3:0] S_RHSEND = 4'd6;
   localparam logic [3:0] S_RDB    = 4'd7;
   localparam logic [3:0] S_BSEL   = 4'd8;
   localparam logic [3:0] S_BDIV   = 4'd9;
   localparam logic [3:0] S_WMUL3  = 4'd10;
   localparam logic [3:0] S_WDIV2  = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;
   localparam logic [3:0] S_SOUT   = 4'd13;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LATCH;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (!stat.is_rhs) begin
               if (stat.row_first) begin
                  op       = OP_ROW0;
                  state_in = S_ROWEND;
               end else begin
                  op       = OP_DIV_L;
                  state_in = S_WDIV1;
               end
            end else if (!stat.ready) begin
               op       = OP_NOT_READY;
               state_in = S_OUT;
            end else if (stat.rhs_first) begin
               op       = OP_FWD0;
               state_in = S_RHSEND;
            end else begin
               op       = OP_MUL_FL;
               state_in = S_WMUL2;
            end
         end
         S_WDIV1: begin
            if (stat.unit_done) begin
               op       = OP_MUL_SL;
               state_in = S_WMUL1;
            end
         end
         S_WMUL1: begin
            if (stat.unit_done) begin
               op       = OP_ROW_WR;
               state_in = S_ROWEND;
            end
         end
         S_ROWEND: begin
            op       = OP_ROW_ADV;
            state_in = stat.row_last ? S_OUT : S_IDLE;
         end
         S_WMUL2: begin
            if (stat.unit_done) begin
               op       = OP_FWD_WR;
               state_in = S_RHSEND;
            end
         end
         S_RHSEND: begin
            op       = OP_RHS_ADV;
            state_in = stat.rhs_last ? S_RDB : S_IDLE;
         end
         S_RDB: begin
            state_in = S_BSEL;
         end
         S_BSEL: begin
            if (stat.back_top) begin
               op       = OP_NUM_FWD;
               state_in = S_BDIV;
            end else begin
               op       = OP_MUL_SN;
               state_in = S_WMUL3;
            end
         end
         S_WMUL3: begin
            if (stat.unit_done) begin
               op       = OP_SUB_N;
               state_in = S_BDIV;
            end
         end
         S_BDIV: begin
            op       = OP_DIV_N;
            state_in = S_WDIV2;
         end
         S_WDIV2: begin
            if (stat.unit_done) begin
               op       = OP_SOL_OUT;
               state_in = S_SOUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         S_SOUT: begin
            if (!rsp_stall) begin
               if (stat.back_zero) begin
                  state_in = S_IDLE;
               end else begin
                  op       = OP_BACK_DEC;
                  state_in = S_RDB;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT) || (state_ff == S_SOUT);

endmodule

>>> rtl/core/tridiagonal_system_solver.sv
// Top level of the tridiagonal system solver: controller plus datapath.
// Row 0 is stored directly; each later row runs a serial divide, then a serial multiply.
// A later rhs request runs one serial multiply before the next request is taken.
// The final rhs request starts back substitution on the shared bit-serial multiply/divide unit:
// each solution element takes a multiply (not for the top one) and a divide, then output wait.
// Synchronous active-high reset clears control state; the stores are undefined until written.
module tridiagonal_system_solver
   import tds_pkg::*;
#(
   parameter int MAX_SIZE   = DEF_MAX_SIZE,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_BITS-1:0]         csr_wdata,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic signed [COEF_BITS-1:0] req_sub_coef,
   input  logic signed [COEF_BITS-1:0] req_main_coef,
   input  logic signed [COEF_BITS-1:0] req_super_coef,
   input  logic signed [COEF_BITS-1:0] req_rhs_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [INDEX_BITS-1:0]       rsp_index,
   output logic signed [COEF_BITS-1:0] rsp_value,
   output logic                        rsp_last
);

   tds_stat_type       stat;
   logic [OP_BITS-1:0] op;

   tds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .op        (op)
   );

   tds_datapath #(
      .MAX_SIZE   (MAX_SIZE),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_cmd        (req_cmd),
      .req_sub_coef   (req_sub_coef),
      .req_main_coef  (req_main_coef),
      .req_super_coef (req_super_coef),
      .req_rhs_value  (req_rhs_value),
      .op             (op),
      .stat           (stat),
      .rsp_status     (rsp_status),
      .rsp_index      (rsp_index),
      .rsp_value      (rsp_value),
      .rsp_last       (rsp_last)
   );

   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a response is pending");

   a_solution_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_SOLUTION) |-> (rsp_last == (rsp_index == '0)))
      else $error("solution last flag does not match index zero");

   a_status_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_SOLUTION) |-> (rsp_last && rsp_index == '0
                                                    && rsp_value == '0))
      else $error("status response not in final form");

endmodule
